// ----- rtl/assert_macros.svh -----
// Assertion macros used by the deframer engine (bsd_engine).
// A_IMPLIES checks a same-cycle implication, A_NEXT checks the cycle after.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define A_IMPLIES(label, clk, rst_n, cond, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
    else $error("assertion failed");
`define A_NEXT(label, clk, rst_n, cond, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
    else $error("assertion failed");
`else
`define A_IMPLIES(label, clk, rst_n, cond, expr)
`define A_NEXT(label, clk, rst_n, cond, expr)
`endif

`endif

// ----- rtl/bsd_pkg.sv -----
package bsd_pkg;

  // Frame length limit, capped at what the 12-bit counter can hold.
  localparam int MAX_FRAME   = 2048;
  localparam int COUNT_W     = 12;
  localparam int COUNT_MAX   = (1 << COUNT_W) - 1;
  localparam int COUNT_LIMIT = (MAX_FRAME < COUNT_MAX) ? MAX_FRAME : COUNT_MAX;

  localparam int BYTE_W      = 8;
  localparam int CFG_INDEX_W = 2;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_START_CODE  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_STOP_CODE   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_ESCAPE_CODE = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [BYTE_W-1:0] START_CODE_RST  = 8'd2;
  localparam logic [BYTE_W-1:0] STOP_CODE_RST   = 8'd3;
  localparam logic [BYTE_W-1:0] ESCAPE_CODE_RST = 8'd16;

  // The three framing codes as one group.
  typedef struct packed {
    logic [BYTE_W-1:0] start_code;
    logic [BYTE_W-1:0] stop_code;
    logic [BYTE_W-1:0] escape_code;
  } bsd_codes_t;

  // One result item.
  typedef struct packed {
    logic [BYTE_W-1:0]  data_byte;
    logic               frame_end;
    logic [COUNT_W-1:0] frame_length;
    logic               length_overflow;
  } bsd_result_t;

endpackage

// ----- rtl/bsd_if.sv -----
// Received byte channel.
interface bsd_in_if import bsd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// Result channel: a data byte or an end-of-frame marker.
interface bsd_out_if import bsd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [BYTE_W-1:0]  data_byte;
  logic               frame_end;
  logic [COUNT_W-1:0] frame_length;
  logic               length_overflow;

  modport source (output valid, output data_byte, output frame_end,
                  output frame_length, output length_overflow, input ready);
  modport sink   (input valid, input data_byte, input frame_end,
                  input frame_length, input length_overflow, output ready);
endinterface

// Configuration write channel.
interface bsd_cfg_if import bsd_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] reg_index;
  logic [BYTE_W-1:0]      wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

// ----- rtl/byte_stuffing_deframer_unit.sv -----
// Byte-stuffing deframer with start, stop and escape codes.
// in_ch carries one received byte per item (valid/ready). Outside a frame,
// bytes are dropped until the start code. Inside a frame, bytes after the
// escape code are data, the stop code yields an end-of-frame item with the
// payload length and an overflow flag, and the escape code itself is dropped.
// out_ch carries data bytes (frame_end low) and end markers (frame_end high).
// cfg_ch writes the start (index 0), stop (1) and escape (2) codes; other
// indexes are ignored. It is always ready; the user must see that it is written
// only while idle, as the block does not enforce this. Throughput is one byte
// per cycle while out_ch is not stalled: the frame state is a handful of bits
// updated by one compare stage between the input register and the result
// register, which drives out_ch; each byte first waits in the input register.
// When the receiver stalls, the result register holds and the input
// register keeps one byte; in_ch.ready drops only when both hold items
// and out_ch.ready is low.
// Synchronous reset sets the codes to 2, 3 and 16, empties both registers
// and returns the deframer to hunting for a start code.
module byte_stuffing_deframer_unit
  import bsd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  bsd_in_if.sink    in_ch,
  bsd_out_if.source out_ch,
  bsd_cfg_if.sink   cfg_ch
);

  bsd_codes_t        codes_r;
  logic              s1_valid_r, s1_valid_nxt;
  logic [BYTE_W-1:0] s1_byte_r;
  logic              out_valid_r, out_valid_nxt;
  bsd_result_t       out_data_r;

  logic        has_result;
  bsd_result_t result;
  logic        out_free;
  logic        s1_adv;
  logic        in_fire;

  // Configuration registers.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      codes_r.start_code  <= START_CODE_RST;
      codes_r.stop_code   <= STOP_CODE_RST;
      codes_r.escape_code <= ESCAPE_CODE_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.reg_index)
        CFG_START_CODE:  codes_r.start_code  <= cfg_ch.wdata;
        CFG_STOP_CODE:   codes_r.stop_code   <= cfg_ch.wdata;
        CFG_ESCAPE_CODE: codes_r.escape_code <= cfg_ch.wdata;
        default: ;
      endcase
    end
  end

  // Pipeline flow control.
  assign out_free     = !out_valid_r || out_ch.ready;
  assign s1_adv       = s1_valid_r && (!has_result || out_free);
  assign in_ch.ready  = !s1_valid_r || s1_adv;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign s1_valid_nxt = in_fire ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = (s1_adv && has_result) ? 1'b1
                       : (out_ch.ready ? 1'b0 : out_valid_r);

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
    if (in_fire) begin
      s1_byte_r <= in_ch.rx_byte;
    end
  end

  bsd_engine u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .codes      (codes_r),
    .step       (s1_adv),
    .rx_byte    (s1_byte_r),
    .has_result (has_result),
    .result     (result)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (s1_adv && has_result) begin
      out_data_r <= result;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.data_byte       = out_data_r.data_byte;
  assign out_ch.frame_end       = out_data_r.frame_end;
  assign out_ch.frame_length    = out_data_r.frame_length;
  assign out_ch.length_overflow = out_data_r.length_overflow;

endmodule

// ----- rtl/bsd_engine.sv -----
`include "assert_macros.svh"

module bsd_engine
  import bsd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  bsd_codes_t        codes,
  input  logic              step,
  input  logic [BYTE_W-1:0] rx_byte,
  output logic              has_result,
  output bsd_result_t       result
);

  localparam logic [COUNT_W-1:0] LIMIT = COUNT_W'(COUNT_LIMIT);

  logic               in_frame_r,       in_frame_nxt;
  logic               escape_pending_r, escape_pending_nxt;
  logic [COUNT_W-1:0] byte_count_r,     byte_count_nxt;
  logic               overflowed_r,     overflowed_nxt;

  // Decide what the current byte does and how the frame state moves.
  always_comb begin
    in_frame_nxt       = in_frame_r;
    escape_pending_nxt = escape_pending_r;
    byte_count_nxt     = byte_count_r;
    overflowed_nxt     = overflowed_r;
    has_result         = 1'b0;
    result             = '0;

    if (!in_frame_r) begin
      // Hunting: only the start code matters.
      if (rx_byte == codes.start_code) begin
        in_frame_nxt       = 1'b1;
        escape_pending_nxt = 1'b0;
        byte_count_nxt     = '0;
        overflowed_nxt     = 1'b0;
      end
    end else if (!escape_pending_r && rx_byte == codes.stop_code) begin
      // Close the frame with an end marker.
      in_frame_nxt           = 1'b0;
      has_result             = 1'b1;
      result.frame_end       = 1'b1;
      result.frame_length    = byte_count_r;
      result.length_overflow = overflowed_r;
      byte_count_nxt         = '0;
      overflowed_nxt         = 1'b0;
    end else if (!escape_pending_r && rx_byte == codes.escape_code) begin
      escape_pending_nxt = 1'b1;
    end else begin
      // Payload byte, literal after an escape or plain otherwise.
      escape_pending_nxt = 1'b0;
      has_result         = 1'b1;
      result.data_byte   = rx_byte;
      if (byte_count_r < LIMIT) begin
        byte_count_nxt = byte_count_r + 1'b1;
      end else begin
        overflowed_nxt = 1'b1;
      end
    end
  end

  // Frame state advances once per consumed item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r       <= 1'b0;
      escape_pending_r <= 1'b0;
      byte_count_r     <= '0;
      overflowed_r     <= 1'b0;
    end else if (step) begin
      in_frame_r       <= in_frame_nxt;
      escape_pending_r <= escape_pending_nxt;
      byte_count_r     <= byte_count_nxt;
      overflowed_r     <= overflowed_nxt;
    end
  end

  `A_IMPLIES(a_count_bound, clk, rst_n, 1'b1, byte_count_r <= LIMIT)
  `A_IMPLIES(a_ovf_at_limit, clk, rst_n, overflowed_r, byte_count_r == LIMIT)
  `A_IMPLIES(a_escape_in_frame, clk, rst_n, escape_pending_r, in_frame_r)
  `A_NEXT(a_end_clears, clk, rst_n, step && has_result && result.frame_end,
          !in_frame_r && byte_count_r == '0 && !overflowed_r)

endmodule
